### rtl/scsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Size-class slab allocator package
// Shared types and fixed constants of the allocator and its sub-blocks.
// ----------------------------------------------------------------------------
package scsa_pkg;

   // Number of class size registers, fixed by the register map.
   localparam int SIZE_REGS  = 4;
   localparam int CLS_W      = 2;
   // Bits of the used bitmap held in one memory word.
   localparam int WORD_BITS  = 8;
   localparam int BIT_W      = 3;
   localparam int SIZE_W     = 13;
   localparam int CNT_W      = 3;
   localparam int OFFSET_W   = 16;
   localparam int GRANT_W    = 14;
   localparam int STATUS_W   = 2;
   localparam int MUL_A_W    = 14;
   localparam int PROD_W     = MUL_A_W + SIZE_W;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_OOM        = 2'd1,
      STATUS_OUTSIDE    = 2'd2,
      STATUS_MISALIGNED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_REGION_BYTES   = 3'd0,
      REG_CLASSES_IN_USE = 3'd1,
      REG_CLASS_SIZE_0   = 3'd2,
      REG_CLASS_SIZE_1   = 3'd3,
      REG_CLASS_SIZE_2   = 3'd4,
      REG_CLASS_SIZE_3   = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_RD,
      ST_SCAN,
      ST_MUL,
      ST_CHK,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   // Handshake between the controller and the divider.
   typedef struct packed {
      logic               start;
      logic [SIZE_W-1:0]  dividend;
      logic [SIZE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SIZE_W-1:0]  quotient;
      logic [SIZE_W-1:0]  remainder;
   } div_rsp_type;

endpackage : scsa_pkg
`default_nettype wire

### rtl/scsa_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slab allocator divider
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module scsa_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  scsa_pkg::div_req_type req,
   output scsa_pkg::div_rsp_type rsp
);
   import scsa_pkg::*;

   localparam int STEP_W = $clog2(SIZE_W + 1);

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[SIZE_W-1]} - {1'b0, req.divisor};
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         cnt_in = STEP_W'(SIZE_W);
      end else if (cnt_ff != '0) begin
         if (!trial[SIZE_W]) begin
            rem_in = trial[SIZE_W-1:0];
            quo_in = {quo_ff[SIZE_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SIZE_W-2:0], quo_ff[SIZE_W-1]};
            quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule : scsa_divider
`default_nettype wire

### rtl/scsa_bitmap_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slab allocator bitmap memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module scsa_bitmap_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire  [ADDR_W-1:0]              wr_addr,
   input  wire  [scsa_pkg::WORD_BITS-1:0] wr_data,
   input  wire                            rd_en,
   input  wire  [ADDR_W-1:0]              rd_addr,
   output logic [scsa_pkg::WORD_BITS-1:0] rd_data
);
   import scsa_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : scsa_bitmap_ram
`default_nettype wire

### rtl/size_class_slab_allocator_top.sv
`default_nettype none
// Allocate reads and scans the 8-slot bitmap words of its class in turn until one
// has a free slot; free waits on the 13-step serial divider. One item is
// processed at a time. Reset: synchronous; afterwards a clearing pass over all
// NUM_CLASSES*ceil(MAX_SLOTS/8) words zeroes the bitmap memory, and no item is
// accepted until it finishes.
// ----------------------------------------------------------------------------
// Size-class slab allocator
// Segregated-fit allocator with one pool region per size class and a used
// bitmap per region, kept in a synchronous memory of 8-bit words.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_top #(
   parameter int NUM_CLASSES = 4,
   parameter int MAX_SLOTS   = 256
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   // tdata: request_bytes[12:0], free_offset[28:13], zero fill [31:29].
   input  wire  [31:0] req_tdata,
   // tuser: func (0 allocate, 1 free).
   input  wire         req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // tdata: status[1:0], granted_offset[15:2].
   output logic [15:0] rsp_tdata,
   // Register write channel.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [12:0] csr_data
);
   import scsa_pkg::*;

   // Memory geometry: each class owns WPC consecutive words.
   localparam int WPC    = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH  = NUM_CLASSES * WPC;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW     = (WPC > 1) ? $clog2(WPC) : 1;
   localparam int SW     = WW + BIT_W;
   localparam int NCLS   = (NUM_CLASSES < SIZE_REGS) ? NUM_CLASSES : SIZE_REGS;

   // Configuration registers.
   logic [SIZE_W-1:0] region_ff;
   logic [CNT_W-1:0]  classes_ff;
   logic [SIZE_W-1:0] class_size_ff [SIZE_REGS];

   state_type         state_ff, state_in;
   logic              op_free_ff;
   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic [WW-1:0]     word_ff;
   logic [SW-1:0]     slot_ff;
   logic [SIZE_W-1:0] within_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ADDR_W-1:0] clr_ff;
   status_type        status_ff;
   logic [GRANT_W-1:0] grant_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   // Request fields.
   logic [SIZE_W-1:0]   req_bytes;
   logic [OFFSET_W-1:0] req_offset;
   logic                accept;
   assign req_bytes  = req_tdata[12:0];
   assign req_offset = req_tdata[28:13];
   assign accept     = req_tvalid && req_tready;

   // Enabled class count, limited by the instance and the register map.
   logic [CNT_W-1:0] ncls;
   assign ncls = (classes_ff > CNT_W'(NCLS)) ? CNT_W'(NCLS) : classes_ff;

   // Allocate: first enabled class whose size covers the request.
   logic             fit_found;
   logic [CLS_W-1:0] fit_cls;
   always_comb begin
      fit_found = 1'b0;
      fit_cls   = '0;
      for (int c = SIZE_REGS - 1; c >= 0; c--) begin
         if ((CNT_W'(c) < ncls) && (class_size_ff[c] >= req_bytes)) begin
            fit_found = 1'b1;
            fit_cls   = CLS_W'(c);
         end
      end
   end

   // Free: region lookup by compares against the first three region bounds.
   logic [OFFSET_W-1:0] pool, r1, r2, r3;
   logic [CLS_W-1:0]    free_cls;
   logic [OFFSET_W-1:0] free_base;
   logic                outside;
   assign pool = OFFSET_W'(ncls) * OFFSET_W'(region_ff);
   assign r1   = OFFSET_W'(region_ff);
   assign r2   = OFFSET_W'(region_ff) << 1;
   assign r3   = r2 + r1;
   assign outside = (req_offset >= pool);
   always_comb begin
      if (req_offset >= r3) begin
         free_cls  = CLS_W'(3);
         free_base = r3;
      end else if (req_offset >= r2) begin
         free_cls  = CLS_W'(2);
         free_base = r2;
      end else if (req_offset >= r1) begin
         free_cls  = CLS_W'(1);
         free_base = r1;
      end else begin
         free_cls  = '0;
         free_base = '0;
      end
   end

   logic [SIZE_W-1:0] cur_size;
   assign cur_size = class_size_ff[cls_ff];

   // Divider.
   div_req_type div_req;
   div_rsp_type div_rsp;
   scsa_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Bitmap memory.
   logic                 wr_en, rd_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr, base_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;
   scsa_bitmap_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign base_addr = ADDR_W'(cls_ff) * ADDR_W'(WPC);

   // Lowest free slot in the word just read. Padding bits past the last slot
   // count as used so they are never handed out.
   logic             scan_found;
   logic [BIT_W-1:0] scan_bit;
   always_comb begin
      scan_found = 1'b0;
      scan_bit   = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (!rd_data[j] && ((int'(word_ff) * WORD_BITS + j) < MAX_SLOTS)) begin
            scan_found = 1'b1;
            scan_bit   = BIT_W'(j);
         end
      end
   end

   // The slot is real only if it lies fully inside the region:
   // (slot + 1) * size <= region_bytes. A class of size zero has no slots.
   logic [MUL_A_W-1:0] mul_a;
   logic               fits_region;
   assign mul_a       = MUL_A_W'(slot_ff) + MUL_A_W'(1);
   assign fits_region = (cur_size != '0) && (prod_ff <= PROD_W'(region_ff));

   logic [GRANT_W-1:0] grant_calc;
   assign grant_calc = GRANT_W'((PROD_W'(cls_ff) * PROD_W'(region_ff))
                                + prod_ff - PROD_W'(cur_size));

   logic div_bad;
   assign div_bad = (div_rsp.remainder != '0) ||
                    (div_rsp.quotient >= SIZE_W'(MAX_SLOTS));

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  state_in = outside ? ST_DONE : ST_SETUP;
               end else begin
                  state_in = fit_found ? ST_RD : ST_DONE;
               end
            end
         end
         ST_SETUP:   state_in = (cur_size == '0) ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) state_in = div_bad ? ST_DONE : ST_MUL;
         end
         ST_RD:      state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_found)                      state_in = ST_MUL;
            else if (word_ff == WW'(WPC - 1))    state_in = ST_DONE;
            else                                 state_in = ST_RD;
         end
         ST_MUL:     state_in = ST_CHK;
         ST_CHK: begin
            if (op_free_ff && fits_region) state_in = ST_FREE_RD;
            else                           state_in = ST_DONE;
         end
         ST_FREE_RD: state_in = ST_FREE_WR;
         ST_FREE_WR: state_in = ST_DONE;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Memory, divider and handshake controls.
   always_comb begin
      req_tready       = (state_ff == ST_IDLE);
      rd_en            = 1'b0;
      rd_addr          = base_addr + ADDR_W'(word_ff);
      wr_en            = 1'b0;
      wr_addr          = base_addr + ADDR_W'(slot_ff[SW-1:BIT_W]);
      wr_data          = rd_data;
      div_req.start    = 1'b0;
      div_req.dividend = within_ff;
      div_req.divisor  = cur_size;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_SETUP:   div_req.start = (cur_size != '0);
         ST_RD:      rd_en = 1'b1;
         ST_CHK: begin
            if (!op_free_ff && fits_region) begin
               wr_en   = 1'b1;
               wr_data = rd_data | (WORD_BITS'(1) << slot_ff[BIT_W-1:0]);
            end
         end
         ST_FREE_RD: begin
            rd_en   = 1'b1;
            rd_addr = base_addr + ADDR_W'(slot_ff[SW-1:BIT_W]);
         end
         ST_FREE_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~(WORD_BITS'(1) << slot_ff[BIT_W-1:0]);
         end
         default: ;
      endcase
   end

   assign cls_in = (req_tuser) ? free_cls : fit_cls;

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            op_free_ff <= req_tuser;
            cls_ff     <= cls_in;
            word_ff    <= '0;
            within_ff  <= SIZE_W'(req_offset - free_base);
            grant_ff   <= '0;
            if (req_tuser) status_ff <= outside ? STATUS_OUTSIDE : STATUS_MISALIGNED;
            else           status_ff <= STATUS_OOM;
         end
         ST_DIV:  if (div_rsp.done) slot_ff <= SW'(div_rsp.quotient);
         ST_SCAN: begin
            slot_ff <= {word_ff, scan_bit};
            word_ff <= word_ff + 1'b1;
         end
         ST_MUL:  prod_ff <= PROD_W'(mul_a) * PROD_W'(cur_size);
         ST_CHK: begin
            if (!op_free_ff && fits_region) begin
               status_ff <= STATUS_OK;
               grant_ff  <= grant_calc;
            end
         end
         ST_FREE_WR: status_ff <= STATUS_OK;
         default: ;
      endcase
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= {grant_ff, status_ff};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         region_ff        <= SIZE_W'(4096);
         classes_ff       <= CNT_W'(4);
         class_size_ff[0] <= SIZE_W'(16);
         class_size_ff[1] <= SIZE_W'(32);
         class_size_ff[2] <= SIZE_W'(64);
         class_size_ff[3] <= SIZE_W'(128);
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                 rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REGION_BYTES:   region_ff        <= csr_data;
               REG_CLASSES_IN_USE: classes_ff       <= csr_data[CNT_W-1:0];
               REG_CLASS_SIZE_0:   class_size_ff[0] <= csr_data;
               REG_CLASS_SIZE_1:   class_size_ff[1] <= csr_data;
               REG_CLASS_SIZE_2:   class_size_ff[2] <= csr_data;
               REG_CLASS_SIZE_3:   class_size_ff[3] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // The bitmap is written only by the clearing pass or a completed update.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_CHK || state_ff == ST_FREE_WR))
      else $error("bitmap write outside an update state");
   // The divider finishes only while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider result arrived outside the divide state");
   // A new response always comes from the completion state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response raised without a completed item");
`endif

endmodule : size_class_slab_allocator_top
`default_nettype wire

### tb/size_class_slab_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class slab allocator checker
// Watches the register, request and response channels of the allocator, keeps
// its own copy of the registers and the used bitmap, predicts the response to
// each accepted request and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_checker #(
   parameter int NUM_CLASSES = 4,
   parameter int MAX_SLOTS   = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [31:0] req_tdata,
   input  wire         req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [12:0] csr_data,
   output int          fail_count,
   output int          pending
);
   import scsa_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [GRANT_W-1:0] offset;
   } alloc_answer_type;

   int unsigned      region_bytes;
   int unsigned      classes_in_use;
   int unsigned      class_size [SIZE_REGS];
   bit               slot_used [NUM_CLASSES*MAX_SLOTS];
   alloc_answer_type answers_due [$];

   function automatic int unsigned slot_count(int unsigned c);
      int unsigned n;
      if (class_size[c] == 0) return 0;
      n = region_bytes / class_size[c];
      return (n > MAX_SLOTS) ? MAX_SLOTS : n;
   endfunction

   // Applies one request to the bitmap copy and returns the answer it earns.
   function automatic alloc_answer_type serve_request(bit is_free, int unsigned bytes,
                                                      int unsigned off);
      alloc_answer_type ans;
      int unsigned      ncls, c, s, in_region, sz;
      bit               found;
      ncls = classes_in_use;
      if (ncls > NUM_CLASSES) ncls = NUM_CLASSES;
      if (ncls > SIZE_REGS) ncls = SIZE_REGS;
      ans.offset = '0;
      found = 0;
      if (!is_free) begin
         ans.status = STATUS_OOM;
         for (c = 0; c < ncls; c++) begin
            if (class_size[c] >= bytes) begin
               found = 1;
               break;
            end
         end
         if (found) begin
            for (s = 0; s < slot_count(c); s++) begin
               if (!slot_used[c*MAX_SLOTS+s]) begin
                  slot_used[c*MAX_SLOTS+s] = 1;
                  ans.status = STATUS_OK;
                  ans.offset = GRANT_W'(c*region_bytes + class_size[c]*s);
                  break;
               end
            end
         end
      end else if (off >= ncls*region_bytes) begin
         ans.status = STATUS_OUTSIDE;
      end else begin
         c = off / region_bytes;
         in_region = off - c*region_bytes;
         sz = class_size[c];
         ans.status = STATUS_MISALIGNED;
         if (sz != 0 && in_region % sz == 0 && in_region / sz < slot_count(c)) begin
            slot_used[c*MAX_SLOTS + in_region/sz] = 0;
            ans.status = STATUS_OK;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      alloc_answer_type want;
      if (reset) begin
         region_bytes = 4096;
         classes_in_use = 4;
         class_size = '{16, 32, 64, 128};
         foreach (slot_used[i]) slot_used[i] = 0;
         answers_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_REGION_BYTES:   region_bytes = csr_data;
               REG_CLASSES_IN_USE: classes_in_use = csr_data[2:0];
               REG_CLASS_SIZE_0:   class_size[0] = csr_data;
               REG_CLASS_SIZE_1:   class_size[1] = csr_data;
               REG_CLASS_SIZE_2:   class_size[2] = csr_data;
               REG_CLASS_SIZE_3:   class_size[3] = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("response item with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[15:2] !== want.offset) begin
                  $error("granted_offset: expected %0d, got %0d", want.offset,
                         rsp_tdata[15:2]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(serve_request(req_tuser, req_tdata[12:0],
                                                req_tdata[28:13]));
      end
      pending = answers_due.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

### tb/size_class_slab_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class slab allocator regression
// Drives allocate and free requests through the allocator in bursts under
// several register settings, with a stalling response side, and reports the
// verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_top_test;
   import scsa_pkg::*;

   localparam int MAX_SLOTS = 256;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tready = 0;
   logic        csr_valid = 0;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_data = '0;
   wire         req_tready, rsp_tvalid, csr_ready;
   wire  [15:0] rsp_tdata;
   int          fail_count, pending;

   // Handshakes seen at the last rising edge, read back at the falling edge.
   logic        req_taken = 0, csr_taken = 0;
   // Set by the stimulus to make the response side hold off for a long stretch.
   bit          long_hold = 0;

   // Stimulus-side copy of the registers, used to pick allocate sizes and to aim frees at real slots.
   int unsigned region_now = 4096, classes_now = 4;
   int unsigned sizes_now [4] = '{16, 32, 64, 128};
   int          burst_left = 0;

   size_class_slab_allocator_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   size_class_slab_allocator_checker CHECK (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      csr_taken <= csr_valid && csr_ready;
   end

   // Response side. It switches at random between always ready, random stalls and
   // mostly stalled, and performs the long hold-off on request.
   initial begin
      int mode, left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(20, 80);
         end
         left--;
         case (mode)
            0: rsp_tready = 1;
            1: rsp_tready = $urandom_range(0, 1);
            default: rsp_tready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offers one request, starting and ending at a falling edge. The valid stays
   // high afterwards while a burst lasts; at its end it drops and a gap may follow.
   task automatic offer_request(bit is_free, int unsigned bytes, int unsigned off);
      req_tvalid = 1;
      req_tuser = is_free;
      req_tdata = {3'b000, off[15:0], bytes[12:0]};
      do @(negedge clock); while (!req_taken);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   // The sender stops and waits until every response has come back, then lets the
   // block settle.
   task automatic wait_drained();
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, int unsigned value);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value[12:0];
      do @(negedge clock); while (!csr_taken);
      csr_valid = 0;
   endtask

   // Rewrites all registers; only called while the block is idle.
   task automatic load_settings(int unsigned rb, int unsigned n, int unsigned s0,
                                int unsigned s1, int unsigned s2, int unsigned s3);
      wait_drained();
      write_reg(REG_REGION_BYTES, rb);
      write_reg(REG_CLASSES_IN_USE, n);
      write_reg(REG_CLASS_SIZE_0, s0);
      write_reg(REG_CLASS_SIZE_1, s1);
      write_reg(REG_CLASS_SIZE_2, s2);
      write_reg(REG_CLASS_SIZE_3, s3);
      region_now = rb;
      classes_now = n;
      sizes_now = '{s0, s1, s2, s3};
   endtask

   // Offset of some existing slot (any offset if the class has none), biased toward
   // the low slots that allocate hands out first so that frees mostly hit used slots.
   function automatic int unsigned slot_offset();
      int unsigned c, n;
      c = $urandom_range(0, classes_now - 1);
      n = region_now / sizes_now[c];
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      if (n == 0) return $urandom_range(0, 65535);
      if ($urandom_range(0, 1) && n > 16) n = 16;
      return c*region_now + sizes_now[c]*$urandom_range(0, n - 1);
   endfunction

   task automatic random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         offer_request(0, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4096)
                       : $urandom_range(0, sizes_now[$urandom_range(0, classes_now-1)]),
                       $urandom_range(0, 65535));
      else if (pick < 87)
         offer_request(1, $urandom_range(0, 8191), slot_offset());
      else
         offer_request(1, $urandom_range(0, 8191), $urandom_range(0, 65535));
   endtask

   initial begin
      int unsigned sz [4], cap, rb, tmp;
      repeat (5) @(negedge clock);
      reset = 0;

      // Directed part under the reset settings: smallest and largest requests,
      // a request that no class fits, double free, misaligned and outside frees.
      offer_request(0, 0, 0);
      offer_request(0, 16, 0);
      offer_request(0, 17, 0);
      offer_request(0, 128, 0);
      offer_request(0, 129, 0);
      offer_request(0, 4096, 0);
      offer_request(1, 0, 0);
      offer_request(1, 0, 0);
      offer_request(1, 0, 8);
      offer_request(1, 0, 16384);
      offer_request(1, 8191, 65535);
      offer_request(1, 0, 4096);
      // One-slot regions: the second allocate finds its region full.
      load_settings(4096, 4, 4096, 4096, 4096, 4096);
      offer_request(0, 4096, 0);
      offer_request(0, 4096, 0);
      offer_request(1, 0, 4095);
      // Slot past the clamp of the slot count.
      load_settings(4096, 1, 1, 2, 3, 4);
      offer_request(1, 0, 256);
      offer_request(0, 1, 0);
      // Region tail that names no slot, and unsorted sizes.
      load_settings(100, 2, 30, 10, 50, 60);
      offer_request(1, 0, 90);
      offer_request(0, 10, 0);
      offer_request(0, 20, 0);
      // Smallest pool of all.
      load_settings(1, 1, 1, 1, 1, 1);
      offer_request(0, 1, 0);
      offer_request(0, 1, 0);
      offer_request(1, 0, 0);
      offer_request(1, 0, 1);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: load_settings(4096, 4, 16, 32, 64, 128);
            1: begin
               // Small regions that fill up quickly, sizes in ascending order.
               rb = $urandom_range(8, 256);
               foreach (sz[i]) sz[i] = $urandom_range(1, rb);
               for (int i = 0; i < 3; i++)
                  for (int j = 0; j < 3 - i; j++)
                     if (sz[j] > sz[j+1]) begin
                        tmp = sz[j]; sz[j] = sz[j+1]; sz[j+1] = tmp;
                     end
               load_settings(rb, $urandom_range(1, 4), sz[0], sz[1], sz[2], sz[3]);
            end
            2: load_settings(4096, $urandom_range(1, 4), 1, 4096, 4096, 4096);
            default: begin
               rb = $urandom_range(1, 4096);
               cap = $urandom_range(0, 1) ? rb : 4096;
               foreach (sz[i]) sz[i] = $urandom_range(1, cap);
               load_settings(rb, $urandom_range(1, 4), sz[0], sz[1], sz[2], sz[3]);
            end
         endcase
         // In two phases the response side holds off while requests keep coming.
         if (phase == 3 || phase == 7) long_hold = 1;
         for (int k = 0; k < 153; k++) random_item();
      end

      wait_drained();
      if (fail_count == 0)
         $display("size_class_slab_allocator_top regression: pass");
      else
         $display("size_class_slab_allocator_top regression: fail");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #20ms;
      $display("size_class_slab_allocator_top regression: fail");
      $finish;
   end

endmodule
